// ----- hdl/fmvu_pkg.sv -----
// ----------------------------------------------------------------------------
// fmvu_pkg
// Types and constants shared by the FM voice activity meter: item payloads,
// the log table and the DAC level thresholds.
// ----------------------------------------------------------------------------
package fmvu_pkg;

  typedef struct packed {
    logic              cmd;
    logic [1:0]        chip;
    logic [2:0]        channel;
    logic [2:0]        algorithm;
    logic signed [7:0] op_sample_0;
    logic signed [7:0] op_sample_1;
    logic signed [7:0] op_sample_2;
    logic signed [7:0] op_sample_3;
    logic [7:0]        dac_value;
    logic              dac_en;
  } in_t;

  typedef struct packed {
    logic [7:0] op_level_0;
    logic [7:0] op_level_1;
    logic [7:0] op_level_2;
    logic [7:0] op_level_3;
    logic [7:0] channel_level;
    logic [8:0] dac_level;
    logic       dac_playing;
  } out_t;

  // item commands
  localparam logic CMD_CHANNEL = 1'b0;
  localparam logic CMD_DAC     = 1'b1;

  localparam logic [2:0] LAST_CHANNEL = 3'd5;
  localparam logic [1:0] LAST_OP      = 2'd3;
  localparam logic [7:0] DAC_DECAY_RESET = 8'd50;
  localparam logic [9:0] MAG_CLAMP       = 10'h01F;

  // dac distance thresholds and levels
  localparam logic [7:0] DAC_HI_0 = 8'hC0;
  localparam logic [7:0] DAC_LO_0 = 8'h40;
  localparam logic [7:0] DAC_HI_1 = 8'hA0;
  localparam logic [7:0] DAC_LO_1 = 8'h60;
  localparam logic [7:0] DAC_HI_2 = 8'h90;
  localparam logic [7:0] DAC_LO_2 = 8'h70;
  localparam logic [8:0] DAC_LVL_0 = 9'h1FF;
  localparam logic [8:0] DAC_LVL_1 = 9'h0FF;
  localparam logic [8:0] DAC_LVL_2 = 9'h07F;
  localparam logic [8:0] DAC_LVL_3 = 9'h03F;

  // ceil(log1.5(n+1) * 29.8)
  localparam logic [7:0] LOG_TABLE [32] = '{
    8'd0,   8'd51,  8'd81,  8'd102, 8'd119, 8'd132, 8'd144, 8'd153,
    8'd162, 8'd170, 8'd177, 8'd183, 8'd189, 8'd194, 8'd200, 8'd204,
    8'd209, 8'd213, 8'd217, 8'd221, 8'd224, 8'd228, 8'd231, 8'd234,
    8'd237, 8'd240, 8'd243, 8'd245, 8'd248, 8'd250, 8'd253, 8'd255
  };

endpackage

// ----- hdl/fm_voice_vu_meter_unit.sv -----
// ----------------------------------------------------------------------------
// fm_voice_vu_meter_unit
// Peak-hold activity meters for FM operators, channels and the DAC.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall / in_data) takes one item at a time:
// a channel item updates four operator meters and one channel meter, a DAC
// item updates the chip's DAC meter. Each item gives one result item on the
// output channel (out_valid / out_stall / out_data).
// A channel item goes through these steps from acceptance to the result
// register: the four operators go one after another through a single level
// unit, each with a registered read of the operator meter memory and an
// update step, then the channel sum takes one more pass and the output state
// loads the result. A DAC item goes through the DAC update and then the
// output state, an item with a chip or channel out of range straight to the
// output state. A new item is taken only once the result is loaded and the
// sequencer is back in idle.
// in_stall is high while an item is being worked on; the next item can be
// taken while the previous result still waits in the output register.
// If the receiver stalls, the result holds and the sequencer waits in its
// output state. Reset clears all meters (operator meters through per-entry
// valid bits) and sets the DAC decay register to 50; no clearing pass.
// The DAC decay register is written through cfg_wr_en / cfg_wr_data.
// ----------------------------------------------------------------------------
module fm_voice_vu_meter_unit #(
  parameter int CHIP_COUNT = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  fmvu_pkg::in_t     in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output fmvu_pkg::out_t    out_data,
  input  logic              cfg_wr_en,
  input  logic [7:0]        cfg_wr_data
);

  // chip field is two bits, so at most four chips are reachable
  localparam int CHIPS    = (CHIP_COUNT < 4) ? CHIP_COUNT : 4;
  localparam int OP_DEPTH = CHIPS * 24;
  localparam int OP_AW    = $clog2(OP_DEPTH);
  localparam int CH_DEPTH = CHIPS * 6;
  localparam int CH_AW    = $clog2(CH_DEPTH);
  localparam int CI_W     = (CHIPS > 1) ? $clog2(CHIPS) : 1;
  localparam logic [2:0] CHIPS_W = 3'(CHIPS);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD   = 6'b000010,
    S_UPD  = 6'b000100,
    S_CHAN = 6'b001000,
    S_DAC  = 6'b010000,
    S_OUT  = 6'b100000
  } st_t;

  st_t                st_r, st_nxt;
  fmvu_pkg::in_t      item_r;
  logic               bad_r;
  logic [1:0]         op_r;
  logic signed [9:0]  sum_r;
  logic [OP_AW-1:0]   addr_r;
  logic [7:0]         rd_data_r;
  logic [7:0]         lvl_r [4];
  logic [7:0]         chan_lvl_r;
  logic [7:0]         decay_r;

  logic [7:0]         op_mem [OP_DEPTH];
  logic [OP_DEPTH-1:0] op_vld_r;
  logic [7:0]         chan_mtr_r [CH_DEPTH];

  logic [7:0]         last_r [CHIPS];
  logic [7:0]         idle_r [CHIPS];
  logic [8:0]         dmtr_r [CHIPS];
  logic [CHIPS-1:0]   dact_r;

  logic               out_valid_r;
  fmvu_pkg::out_t     out_data_r;

  logic               accept;
  logic               out_load;
  logic               in_bad;
  logic [7:0]         op_addr_full;
  logic [OP_AW-1:0]   op_addr;
  logic [5:0]         ci_full;
  logic [CH_AW-1:0]   ci;
  logic [CI_W-1:0]    c;
  logic signed [7:0]  samp;
  logic signed [9:0]  samp_x;
  logic               carrier;
  logic signed [9:0]  u_operand;
  logic [7:0]         u_cur;
  logic [7:0]         u_level;

  logic               d_playing;
  logic [8:0]         d_lvl;
  logic [7:0]         d_idle_inc;
  logic [8:0]         d_mtr_nxt;
  logic [7:0]         d_idle_nxt;
  fmvu_pkg::out_t     out_nxt;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (st_r != S_IDLE);
  assign out_load = (st_r == S_OUT) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_bad = ({1'b0, in_data.chip} >= CHIPS_W) ||
                  ((in_data.cmd == fmvu_pkg::CMD_CHANNEL) &&
                   (in_data.channel > fmvu_pkg::LAST_CHANNEL));

  assign op_addr_full = 8'(item_r.chip) * 8'd24 + 8'(item_r.channel) * 8'd4 + 8'(op_r);
  assign op_addr      = op_addr_full[OP_AW-1:0];
  assign ci_full      = 6'(item_r.chip) * 6'd6 + 6'(item_r.channel);
  assign ci           = ci_full[CH_AW-1:0];
  assign c            = item_r.chip[CI_W-1:0];

  always_comb begin
    case (op_r)
      2'd0:    samp = item_r.op_sample_0;
      2'd1:    samp = item_r.op_sample_1;
      2'd2:    samp = item_r.op_sample_2;
      default: samp = item_r.op_sample_3;
    endcase
    samp_x = {{2{samp[7]}}, samp};
    carrier = (op_r == 2'd3) ||
              ((op_r == 2'd2) && (item_r.algorithm >= 3'd5)) ||
              ((op_r == 2'd1) && (item_r.algorithm >= 3'd4)) ||
              ((op_r == 2'd0) && (item_r.algorithm == 3'd7));
    if (st_r == S_CHAN) begin
      u_operand = sum_r;
      u_cur     = chan_mtr_r[ci];
    end else begin
      u_operand = samp_x;
      u_cur     = op_vld_r[addr_r] ? rd_data_r : 8'd0;
    end
  end

  fmvu_level_unit u_level_unit (
    .operand (u_operand),
    .cur     (u_cur),
    .level   (u_level)
  );

  // dac meter update for the item's chip
  always_comb begin
    d_playing  = item_r.dac_en && (item_r.dac_value != last_r[c]);
    d_idle_inc = idle_r[c] + 8'd1;
    if (item_r.dac_value >= fmvu_pkg::DAC_HI_0 || item_r.dac_value < fmvu_pkg::DAC_LO_0) begin
      d_lvl = fmvu_pkg::DAC_LVL_0;
    end else if (item_r.dac_value >= fmvu_pkg::DAC_HI_1 ||
                 item_r.dac_value < fmvu_pkg::DAC_LO_1) begin
      d_lvl = fmvu_pkg::DAC_LVL_1;
    end else if (item_r.dac_value >= fmvu_pkg::DAC_HI_2 ||
                 item_r.dac_value < fmvu_pkg::DAC_LO_2) begin
      d_lvl = fmvu_pkg::DAC_LVL_2;
    end else begin
      d_lvl = fmvu_pkg::DAC_LVL_3;
    end
    d_mtr_nxt  = dmtr_r[c];
    d_idle_nxt = idle_r[c];
    if (d_playing) begin
      d_mtr_nxt  = d_lvl;
      d_idle_nxt = 8'd0;
    end else if (!item_r.dac_en) begin
      d_mtr_nxt = 9'd0;
    end else if (d_idle_inc > decay_r) begin
      d_mtr_nxt  = {1'b0, dmtr_r[c][8:1]};
      d_idle_nxt = 8'd0;
    end else begin
      d_idle_nxt = d_idle_inc;
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: begin
        if (accept) begin
          if (in_bad) begin
            st_nxt = S_OUT;
          end else if (in_data.cmd == fmvu_pkg::CMD_DAC) begin
            st_nxt = S_DAC;
          end else begin
            st_nxt = S_RD;
          end
        end
      end
      S_RD:   st_nxt = S_UPD;
      S_UPD:  st_nxt = (op_r == fmvu_pkg::LAST_OP) ? S_CHAN : S_RD;
      S_CHAN: st_nxt = S_OUT;
      S_DAC:  st_nxt = S_OUT;
      S_OUT:  st_nxt = out_load ? S_IDLE : S_OUT;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_nxt = '0;
    if (!bad_r) begin
      if (item_r.cmd == fmvu_pkg::CMD_CHANNEL) begin
        out_nxt.op_level_0    = lvl_r[0];
        out_nxt.op_level_1    = lvl_r[1];
        out_nxt.op_level_2    = lvl_r[2];
        out_nxt.op_level_3    = lvl_r[3];
        out_nxt.channel_level = chan_lvl_r;
      end
      out_nxt.dac_level   = dmtr_r[c];
      out_nxt.dac_playing = dact_r[c];
    end
  end

  // control and meter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
      decay_r     <= fmvu_pkg::DAC_DECAY_RESET;
      op_vld_r    <= '0;
      dact_r      <= '0;
      for (int i = 0; i < CH_DEPTH; i++) begin
        chan_mtr_r[i] <= 8'd0;
      end
      for (int i = 0; i < CHIPS; i++) begin
        last_r[i] <= 8'd0;
        idle_r[i] <= 8'd0;
        dmtr_r[i] <= 9'd0;
      end
    end else begin
      st_r <= st_nxt;
      if (cfg_wr_en) begin
        decay_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (st_r == S_UPD) begin
        op_vld_r[addr_r] <= 1'b1;
      end
      if (st_r == S_CHAN) begin
        chan_mtr_r[ci] <= u_level;
      end
      if (st_r == S_DAC) begin
        dact_r[c] <= d_playing;
        dmtr_r[c] <= d_mtr_nxt;
        idle_r[c] <= d_idle_nxt;
        last_r[c] <= item_r.dac_value;
      end
    end
  end

  // operator meter memory, registered read
  always_ff @(posedge clk) begin
    if (st_r == S_UPD) begin
      op_mem[addr_r] <= u_level;
    end
    if (st_r == S_RD) begin
      rd_data_r <= op_mem[op_addr];
    end
  end

  // item and datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
      bad_r  <= in_bad;
      op_r   <= 2'd0;
      sum_r  <= 10'sd0;
    end
    if (st_r == S_RD) begin
      addr_r <= op_addr;
    end
    if (st_r == S_UPD) begin
      lvl_r[op_r] <= u_level;
      sum_r       <= sum_r + (carrier ? samp_x : 10'sd0);
      op_r        <= op_r + 2'd1;
    end
    if (st_r == S_CHAN) begin
      chan_lvl_r <= u_level;
    end
    if (out_load) begin
      out_data_r <= out_nxt;
    end
  end

  // a valid DAC item goes straight to the DAC update
  a_dac_path: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_bad && (in_data.cmd == fmvu_pkg::CMD_DAC) |=> st_r == S_DAC)
    else $error("valid dac item did not enter dac update");

  // the channel pass follows the fourth operator
  a_op_count: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_UPD) && (op_r == fmvu_pkg::LAST_OP) |=> st_r == S_CHAN)
    else $error("operator sequence did not end after four operators");

  // a new result appears only from the output state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r == S_OUT))
    else $error("result raised outside output state");

endmodule

// ----- hdl/fmvu_level_unit.sv -----
// ----------------------------------------------------------------------------
// fmvu_level_unit
// Shared meter unit: magnitude, clamp to 31, log table, then peak hold
// against the current meter value with a decay of one.
// ----------------------------------------------------------------------------
module fmvu_level_unit (
  input  logic signed [9:0] operand,
  input  logic [7:0]        cur,
  output logic [7:0]        level
);

  logic [9:0] mag;
  logic [4:0] idx;
  logic [7:0] lg;

  always_comb begin
    // -512 maps to 10'h200, read as unsigned it is 512
    mag = operand[9] ? (~operand + 10'd1) : operand;
    idx = (mag > fmvu_pkg::MAG_CLAMP) ? 5'h1F : mag[4:0];
    lg  = fmvu_pkg::LOG_TABLE[idx];
    if (lg > cur) begin
      level = lg;
    end else begin
      level = (cur != 8'd0) ? (cur - 8'd1) : 8'd0;
    end
  end

endmodule

// ----- sim/fm_voice_vu_meter_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fm_voice_vu_meter_unit_tb
// Self-checking bench for the FM voice activity meters. A queue-fed driver
// sends channel and DAC items, a scoreboard predicts every meter reading from
// its own copy of the meter state, and a monitor checks each reading in order
// while both sides insert random gaps and one side holds off for long spells.
// ----------------------------------------------------------------------------
module fm_voice_vu_meter_unit_tb;

  localparam bit [7:0] LOG_LEVELS [32] = '{
    8'd0,   8'd51,  8'd81,  8'd102, 8'd119, 8'd132, 8'd144, 8'd153,
    8'd162, 8'd170, 8'd177, 8'd183, 8'd189, 8'd194, 8'd200, 8'd204,
    8'd209, 8'd213, 8'd217, 8'd221, 8'd224, 8'd228, 8'd231, 8'd234,
    8'd237, 8'd240, 8'd243, 8'd245, 8'd248, 8'd250, 8'd253, 8'd255
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  fmvu_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  fmvu_pkg::out_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'd0;

  // predicted meter state
  bit [7:0] op_meter [4][6][4];
  bit [7:0] chan_meter [4][6];
  bit [7:0] dac_last [4];
  bit [7:0] dac_idle [4];
  bit [8:0] dac_meter_q [4];
  bit dac_on [4];
  bit [7:0] decay_ticks = 8'd50;

  fmvu_pkg::in_t pending_items [$];
  fmvu_pkg::out_t meter_readings_due [$];
  bit [7:0] dac_byte_sent [4];
  bit sender_idles = 1'b0;
  bit receiver_idles = 1'b0;
  int send_gap = 0;
  int hold_left = 0;
  int readings_seen = 0;
  int mismatches = 0;

  fm_voice_vu_meter_unit #(
    .CHIP_COUNT(4)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #10 clk = ~clk;

  function automatic bit [7:0] log_level(int v);
    int m;
    m = (v < 0) ? -v : v;
    if (m > 31) m = 31;
    return LOG_LEVELS[m];
  endfunction

  function automatic bit [7:0] hold_peak(bit [7:0] cur, bit [7:0] lvl);
    if (lvl > cur) return lvl;
    return (cur != 8'd0) ? cur - 8'd1 : 8'd0;
  endfunction

  function automatic fmvu_pkg::out_t advance_meters(fmvu_pkg::in_t it);
    fmvu_pkg::out_t r;
    bit [7:0] raw [4];
    int sum;
    int s;
    int k;
    int c;
    bit carrier;
    bit playing;
    r = '0;
    c = it.chip;
    if (it.cmd == fmvu_pkg::CMD_CHANNEL) begin
      if (it.channel > 3'd5) return r;
      raw[0] = it.op_sample_0;
      raw[1] = it.op_sample_1;
      raw[2] = it.op_sample_2;
      raw[3] = it.op_sample_3;
      sum = 0;
      for (k = 0; k < 4; k++) begin
        s = int'($signed(raw[k]));
        carrier = (k == 3) || (k == 2 && it.algorithm >= 5) ||
                  (k == 1 && it.algorithm >= 4) || (k == 0 && it.algorithm == 7);
        if (carrier) sum += s;
        op_meter[c][it.channel][k] = hold_peak(op_meter[c][it.channel][k], log_level(s));
      end
      r.op_level_0 = op_meter[c][it.channel][0];
      r.op_level_1 = op_meter[c][it.channel][1];
      r.op_level_2 = op_meter[c][it.channel][2];
      r.op_level_3 = op_meter[c][it.channel][3];
      chan_meter[c][it.channel] = hold_peak(chan_meter[c][it.channel], log_level(sum));
      r.channel_level = chan_meter[c][it.channel];
    end else begin
      playing = it.dac_en && (it.dac_value != dac_last[c]);
      dac_on[c] = playing;
      if (playing) begin
        // farther from mid-scale gives a higher level
        if (it.dac_value >= 8'hC0 || it.dac_value < 8'h40) dac_meter_q[c] = 9'h1FF;
        else if (it.dac_value >= 8'hA0 || it.dac_value < 8'h60) dac_meter_q[c] = 9'h0FF;
        else if (it.dac_value >= 8'h90 || it.dac_value < 8'h70) dac_meter_q[c] = 9'h07F;
        else dac_meter_q[c] = 9'h03F;
        dac_idle[c] = 8'd0;
      end else if (!it.dac_en) begin
        dac_meter_q[c] = 9'd0;
      end else begin
        dac_idle[c] = dac_idle[c] + 8'd1;
        if (dac_idle[c] > decay_ticks) begin
          dac_meter_q[c] = dac_meter_q[c] >> 1;
          dac_idle[c] = 8'd0;
        end
      end
      dac_last[c] = it.dac_value;
    end
    r.dac_level = dac_meter_q[c];
    r.dac_playing = dac_on[c];
    return r;
  endfunction

  task automatic check_reading(fmvu_pkg::out_t got);
    fmvu_pkg::out_t want;
    if (meter_readings_due.size() == 0) begin
      $error("unexpected meter reading %h", got);
      mismatches++;
      return;
    end
    want = meter_readings_due.pop_front();
    if (got.op_level_0 !== want.op_level_0) begin
      $error("op_level_0 expected %0d got %0d", want.op_level_0, got.op_level_0);
      mismatches++;
    end
    if (got.op_level_1 !== want.op_level_1) begin
      $error("op_level_1 expected %0d got %0d", want.op_level_1, got.op_level_1);
      mismatches++;
    end
    if (got.op_level_2 !== want.op_level_2) begin
      $error("op_level_2 expected %0d got %0d", want.op_level_2, got.op_level_2);
      mismatches++;
    end
    if (got.op_level_3 !== want.op_level_3) begin
      $error("op_level_3 expected %0d got %0d", want.op_level_3, got.op_level_3);
      mismatches++;
    end
    if (got.channel_level !== want.channel_level) begin
      $error("channel_level expected %0d got %0d", want.channel_level, got.channel_level);
      mismatches++;
    end
    if (got.dac_level !== want.dac_level) begin
      $error("dac_level expected %0d got %0d", want.dac_level, got.dac_level);
      mismatches++;
    end
    if (got.dac_playing !== want.dac_playing) begin
      $error("dac_playing expected %0d got %0d", want.dac_playing, got.dac_playing);
      mismatches++;
    end
  endtask

  // mostly short pauses, now and then a long one
  function automatic int pick_pause();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic bit [7:0] rand_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 8'($urandom_range(0, 255));
    if (r < 75) return 8'($urandom_range(0, 62) - 31);
    if (r < 85) begin
      case ($urandom_range(0, 3))
        0: return 8'h7F;
        1: return 8'h80;
        2: return 8'h81;
        default: return 8'h01;
      endcase
    end
    return 8'h00;
  endfunction

  function automatic fmvu_pkg::in_t random_item();
    fmvu_pkg::in_t it;
    it.chip = 2'($urandom_range(0, 3));
    it.algorithm = 3'($urandom_range(0, 7));
    it.op_sample_0 = rand_sample();
    it.op_sample_1 = rand_sample();
    it.op_sample_2 = rand_sample();
    it.op_sample_3 = rand_sample();
    it.dac_en = ($urandom_range(0, 99) < 90);
    if ($urandom_range(0, 99) < 65) begin
      it.cmd = fmvu_pkg::CMD_CHANNEL;
      it.channel = ($urandom_range(0, 99) < 92) ? 3'($urandom_range(0, 5))
                                                 : 3'($urandom_range(6, 7));
      it.dac_value = 8'($urandom_range(0, 255));
    end else begin
      it.cmd = fmvu_pkg::CMD_DAC;
      it.channel = 3'($urandom_range(0, 7));
      // repeating the byte counts as an idle tick
      it.dac_value = ($urandom_range(0, 1) == 0) ? dac_byte_sent[it.chip]
                                                  : 8'($urandom_range(0, 255));
      dac_byte_sent[it.chip] = it.dac_value;
    end
    return it;
  endfunction

  task automatic push_channel(int chip, int ch, int alg, int s0, int s1, int s2, int s3);
    fmvu_pkg::in_t it;
    it = '0;
    it.cmd = fmvu_pkg::CMD_CHANNEL;
    it.chip = 2'(chip);
    it.channel = 3'(ch);
    it.algorithm = 3'(alg);
    it.op_sample_0 = 8'(s0);
    it.op_sample_1 = 8'(s1);
    it.op_sample_2 = 8'(s2);
    it.op_sample_3 = 8'(s3);
    pending_items.push_back(it);
  endtask

  task automatic push_dac(int chip, bit [7:0] b, bit en);
    fmvu_pkg::in_t it;
    it = '0;
    it.cmd = fmvu_pkg::CMD_DAC;
    it.chip = 2'(chip);
    it.dac_value = b;
    it.dac_en = en;
    dac_byte_sent[chip] = b;
    pending_items.push_back(it);
  endtask

  // a fresh byte to light the meter, then the same byte over and over
  task automatic push_idle_run(int chip, int n);
    bit [7:0] b;
    b = dac_byte_sent[chip] ^ 8'h80;
    repeat (n + 1) push_dac(chip, b, 1'b1);
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || meter_readings_due.size() != 0)
      @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic run_phase(int n, bit tx_idle, bit rx_idle);
    sender_idles = tx_idle;
    receiver_idles = rx_idle;
    repeat (n) pending_items.push_back(random_item());
    wait_drained();
  endtask

  task automatic set_decay(bit [7:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    decay_ticks = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // driver: the front of the queue is the item on the bus until it is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        meter_readings_due.push_back(advance_meters(in_data));
        void'(pending_items.pop_front());
        send_gap = (sender_idles && $urandom_range(0, 99) < 40) ? pick_pause() : 0;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= pending_items[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        check_reading(out_data);
        readings_seen++;
        // long hold-off so the block backs up into its input
        if (readings_seen % 250 == 60) hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (receiver_idles && $urandom_range(0, 99) < 25) begin
        hold_left = pick_pause() - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #20_000_000;
    $display("fm_voice_vu_meter_unit regression: fail");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // operator and carrier extremes, every algorithm
    push_channel(0, 0, 0, 127, 127, 127, 127);
    push_channel(0, 0, 0, -128, -128, -128, -128);
    push_channel(0, 0, 0, 0, 0, 0, 0);
    push_channel(1, 5, 7, 127, 127, 127, 127);
    push_channel(1, 5, 7, -128, -128, -128, -128);
    push_channel(2, 1, 1, 5, -5, 31, -32);
    push_channel(2, 2, 2, 1, 2, 3, -1);
    push_channel(2, 3, 3, 30, -30, 2, -2);
    push_channel(3, 4, 4, 10, -20, 0, 11);
    push_channel(3, 4, 5, -1, 1, 1, 1);
    push_channel(3, 0, 6, 100, -100, 50, -50);
    // channel out of range
    push_channel(0, 6, 2, 127, -128, 127, -128);
    push_channel(1, 7, 7, -128, 127, -1, 1);
    // dac bands at their edges, an unchanged byte and a disable
    push_dac(0, 8'h00, 1'b1);
    push_dac(0, 8'hC0, 1'b1);
    push_dac(0, 8'hBF, 1'b1);
    push_dac(0, 8'h40, 1'b1);
    push_dac(0, 8'h9F, 1'b1);
    push_dac(0, 8'h60, 1'b1);
    push_dac(0, 8'h8F, 1'b1);
    push_dac(0, 8'h70, 1'b1);
    push_dac(0, 8'h70, 1'b1);
    push_dac(0, 8'h70, 1'b0);
    push_dac(3, 8'hFF, 1'b1);
    run_phase(0, 1'b0, 1'b0);

    set_decay(8'd50);
    push_idle_run(2, 55);
    run_phase(70, 1'b1, 1'b1);

    set_decay(8'd1);
    run_phase(80, 1'b0, 1'b1);

    // halves on every idle tick
    set_decay(8'd0);
    run_phase(50, 1'b1, 1'b0);

    // never decays; the idle count wraps
    set_decay(8'd255);
    push_idle_run(1, 258);
    run_phase(30, 1'b1, 1'b1);

    set_decay(8'($urandom_range(2, 254)));
    run_phase(70, 1'b1, 1'b1);

    set_decay(8'd3);
    run_phase(50, 1'b0, 1'b0);

    wait_drained();
    if (mismatches == 0) begin
      $display("fm_voice_vu_meter_unit regression: pass");
    end else begin
      $display("fm_voice_vu_meter_unit regression: fail");
    end
    $finish;
  end

endmodule
